// File: hdl/sbl_pkg.sv
// Shared types, codes and character helpers for the script byte lexer.
package sbl_pkg;

  localparam int MaxIdentLen = 63;
  localparam int CntW        = $clog2(MaxIdentLen + 1);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_SYM, M_IDENT, M_ZERO, M_DEC, M_OCT,
    M_HEXSTART, M_HEX, M_STR, M_STRESC, M_STRHEX1, M_STRHEX2
  } mode_t;

  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_SBYTE = 2'd1;
  localparam logic [1:0] RK_IBYTE = 2'd2;
  localparam logic [1:0] RK_ERROR = 2'd3;

  localparam logic [4:0] TK_END    = 5'd0;
  localparam logic [4:0] TK_IDENT  = 5'd18;
  localparam logic [4:0] TK_INT    = 5'd19;
  localparam logic [4:0] TK_STRING = 5'd20;
  localparam logic [4:0] TK_AND2   = 5'd21;
  localparam logic [4:0] TK_OR2    = 5'd22;
  localparam logic [4:0] TK_NE     = 5'd23;
  localparam logic [4:0] TK_EQ     = 5'd24;
  localparam logic [4:0] TK_LE     = 5'd25;
  localparam logic [4:0] TK_GE     = 5'd26;
  localparam logic [4:0] TK_KW0    = 5'd27;

  localparam logic [2:0] ER_NONE    = 3'd0;
  localparam logic [2:0] ER_UNTERM  = 3'd1;
  localparam logic [2:0] ER_ESCAPE  = 3'd2;
  localparam logic [2:0] ER_LONG    = 3'd3;
  localparam logic [2:0] ER_HEX     = 3'd4;
  localparam logic [2:0] ER_UNKNOWN = 3'd5;

  typedef struct packed {
    logic [1:0]        kind;
    logic [4:0]        tok;
    logic signed [31:0] ival;
    logic [7:0]        ch;
    logic [5:0]        len;
    logic [2:0]        err;
    logic              last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [4:0] tok, logic [31:0] ival,
                                  logic [7:0] ch, logic [5:0] len, logic [2:0] err);
    res_t r;
    r.kind = kind; r.tok = tok; r.ival = ival; r.ch = ch;
    r.len = len; r.err = err; r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // 16 means not a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [7:0] t;
    t = 8'd16;
    if (is_digit(b)) t = b - "0";
    else if (b >= "a" && b <= "f") t = b - "a" + 8'd10;
    else if (b >= "A" && b <= "F") t = b - "A" + 8'd10;
    return t[4:0];
  endfunction

  function automatic logic [4:0] single_tok(logic [7:0] b);
    logic [4:0] t;
    case (b)
      "+": t = 5'd1;   "-": t = 5'd2;   "*": t = 5'd3;   "/": t = 5'd4;
      "^": t = 5'd5;   "~": t = 5'd6;   ";": t = 5'd7;   "%": t = 5'd8;
      "(": t = 5'd9;   ")": t = 5'd10;  ",": t = 5'd11;  "&": t = 5'd12;
      "|": t = 5'd13;  "<": t = 5'd14;  ">": t = 5'd15;  "=": t = 5'd16;
      "!": t = 5'd17;
      default: t = TK_END;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] pair_tok(logic [7:0] a, logic [7:0] b);
    logic [4:0] t;
    t = TK_END;
    if (a == "&" && b == "&") t = TK_AND2;
    else if (a == "|" && b == "|") t = TK_OR2;
    else if (b == "=") begin
      if (a == "!") t = TK_NE;
      else if (a == "=") t = TK_EQ;
      else if (a == "<") t = TK_LE;
      else if (a == ">") t = TK_GE;
    end
    return t;
  endfunction

  localparam logic [CntW-1:0] KwLen [3] = '{CntW'(7), CntW'(4), CntW'(5)};

  // keyword text: declare, true, false
  function automatic logic [7:0] kw_char(int k, logic [2:0] i);
    logic [7:0] c;
    c = 8'd0;
    case (k)
      0: case (i)
        3'd0: c = "d"; 3'd1: c = "e"; 3'd2: c = "c"; 3'd3: c = "l";
        3'd4: c = "a"; 3'd5: c = "r"; 3'd6: c = "e"; default: c = 8'd0;
      endcase
      1: case (i)
        3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
        default: c = 8'd0;
      endcase
      default: case (i)
        3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
        3'd4: c = "e"; default: c = 8'd0;
      endcase
    endcase
    return c;
  endfunction

endpackage

// File: hdl/sbl_in_if.sv
// Input channel: source byte plus end-of-text mark.
interface sbl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_mark;
  modport source (output valid, src_byte, end_mark, input ready);
  modport sink (input valid, src_byte, end_mark, output ready);
endinterface

// File: hdl/sbl_out_if.sv
// Result channel: one token, byte or error per item.
interface sbl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [4:0]         token_kind;
  logic signed [31:0] int_value;
  logic [7:0]         char_value;
  logic [5:0]         ident_length;
  logic [2:0]         error_code;
  logic               last_of_run;
  modport source (output valid, result_kind, token_kind, int_value, char_value,
                  ident_length, error_code, last_of_run, input ready);
  modport sink (input valid, result_kind, token_kind, int_value, char_value,
                ident_length, error_code, last_of_run, output ready);
endinterface

// File: hdl/sbl_core.sv
// Lexer state registers and the per-byte next-state and result logic.
module sbl_core
  import sbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] b,
  input  logic       endm,
  output logic [1:0] n_res,
  output res_t       res0,
  output res_t       res1
);

  mode_t           mode_r, mode_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [2:0]      kwc_r, kwc_nxt;
  logic [7:0]      pend_r, pend_nxt;
  logic [3:0]      nib_r, nib_nxt;
  logic            err_r, err_nxt;

  res_t       rr [2];
  logic [1:0] n;
  logic       do_fin, do_add;
  logic [4:0] h, t;
  logic [7:0] c, hx;

  // one step of the lexer, in model order: mode logic, finish, start, add
  always_comb begin
    mode_nxt = mode_r; acc_nxt = acc_r; cnt_nxt = cnt_r; kwc_nxt = kwc_r;
    pend_nxt = pend_r; nib_nxt = nib_r; err_nxt = err_r;
    rr[0] = '0; rr[1] = '0; n = 2'd0;
    do_fin = 1'b0; do_add = 1'b0;
    h = hex_val(b); t = TK_END; c = b; hx = {nib_r, h[3:0]};

    if (endm) begin
      do_fin = !err_r;
    end else if (!err_r) begin
      case (mode_r)
        M_COMMENT: if (b == 8'd13 || b == 8'd10) mode_nxt = M_IDLE;
        M_SYM: begin
          t = pair_tok(pend_r, b);
          if (pend_r == "/" && b == "/") mode_nxt = M_COMMENT;
          else if (t != TK_END) begin
            rr[n[0]] = mk_res(RK_TOKEN, t, '0, '0, '0, ER_NONE); n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else do_fin = 1'b1;
        end
        M_IDENT: begin
          if (b == "_" || is_alpha(b) || is_digit(b)) do_add = 1'b1;
          else do_fin = 1'b1;
        end
        M_ZERO: begin
          if (b == "x") begin
            acc_nxt = '0; mode_nxt = M_HEXSTART;
          end else if (b >= "0" && b <= "7") begin
            acc_nxt = {29'd0, b[2:0]}; mode_nxt = M_OCT;
          end else do_fin = 1'b1;
        end
        M_OCT: begin
          if (b >= "0" && b <= "7") acc_nxt = {acc_r[28:0], b[2:0]};
          else do_fin = 1'b1;
        end
        M_DEC: begin
          if (is_digit(b)) acc_nxt = (acc_r << 3) + (acc_r << 1) + {28'd0, b[3:0]};
          else do_fin = 1'b1;
        end
        M_HEXSTART: begin
          if (h[4]) begin
            rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_HEX); n = n + 2'd1;
            err_nxt = 1'b1; mode_nxt = M_IDLE;
          end else begin
            acc_nxt = {28'd0, h[3:0]}; mode_nxt = M_HEX;
          end
        end
        M_HEX: begin
          if (!h[4]) acc_nxt = {acc_r[27:0], h[3:0]};
          else do_fin = 1'b1;
        end
        M_STR: begin
          if (b == "\"") begin
            rr[n[0]] = mk_res(RK_TOKEN, TK_STRING, '0, '0, '0, ER_NONE); n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else if (b == 8'd13 || b == 8'd10) begin
            rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_UNTERM); n = n + 2'd1;
            err_nxt = 1'b1; mode_nxt = M_IDLE;
          end else if (b == "\\") mode_nxt = M_STRESC;
          else begin
            rr[n[0]] = mk_res(RK_SBYTE, TK_END, '0, b, '0, ER_NONE); n = n + 2'd1;
          end
        end
        M_STRESC: begin
          case (b)
            "a": c = 8'd7;  "b": c = 8'd8;  "f": c = 8'd12; "n": c = 8'd10;
            "r": c = 8'd13; "t": c = 8'd9;  "v": c = 8'd11;
            default: c = b;
          endcase
          if (b == "x") mode_nxt = M_STRHEX1;
          else if (c == 8'd0) begin
            rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_ESCAPE); n = n + 2'd1;
            err_nxt = 1'b1; mode_nxt = M_IDLE;
          end else begin
            rr[n[0]] = mk_res(RK_SBYTE, TK_END, '0, c, '0, ER_NONE); n = n + 2'd1;
            mode_nxt = M_STR;
          end
        end
        M_STRHEX1: begin
          if (h[4]) begin
            rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_ESCAPE); n = n + 2'd1;
            err_nxt = 1'b1; mode_nxt = M_IDLE;
          end else begin
            nib_nxt = h[3:0]; mode_nxt = M_STRHEX2;
          end
        end
        M_STRHEX2: begin
          if (h[4] || hx == 8'd0) begin
            rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_ESCAPE); n = n + 2'd1;
            err_nxt = 1'b1; mode_nxt = M_IDLE;
          end else begin
            rr[n[0]] = mk_res(RK_SBYTE, TK_END, '0, hx, '0, ER_NONE); n = n + 2'd1;
            mode_nxt = M_STR;
          end
        end
        default: begin
          mode_nxt = M_IDLE; do_fin = 1'b1;
        end
      endcase
    end

    // flush whatever token the mode holds
    if (do_fin) begin
      case (mode_nxt)
        M_SYM: begin
          rr[n[0]] = mk_res(RK_TOKEN, single_tok(pend_r), '0, '0, '0, ER_NONE);
          n = n + 2'd1;
        end
        M_IDENT: begin
          t = TK_IDENT;
          for (int k = 0; k < 3; k++)
            if (kwc_r[k] && cnt_r == KwLen[k]) t = TK_KW0 + 5'(k);
          rr[n[0]] = mk_res(RK_TOKEN, t, '0, '0, cnt_r[5:0], ER_NONE); n = n + 2'd1;
        end
        M_ZERO, M_DEC, M_OCT, M_HEX: begin
          rr[n[0]] = mk_res(RK_TOKEN, TK_INT, acc_nxt, '0, '0, ER_NONE); n = n + 2'd1;
        end
        M_HEXSTART: begin
          rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_HEX); n = n + 2'd1;
          err_nxt = 1'b1;
        end
        M_STR: begin
          rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_UNTERM); n = n + 2'd1;
          err_nxt = 1'b1;
        end
        M_STRESC, M_STRHEX1, M_STRHEX2: begin
          rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_ESCAPE); n = n + 2'd1;
          err_nxt = 1'b1;
        end
        default: ;
      endcase
      mode_nxt = M_IDLE;

      // lex the same byte as the start of a new token
      if (!endm && !err_nxt && !is_space(b)) begin
        if (b == "\"") mode_nxt = M_STR;
        else if (b == "_" || is_alpha(b)) begin
          mode_nxt = M_IDENT; cnt_nxt = '0; kwc_nxt = 3'b111; do_add = 1'b1;
        end else if (is_digit(b)) begin
          acc_nxt = {28'd0, b[3:0]};
          mode_nxt = (b == "0") ? M_ZERO : M_DEC;
        end else if (b == "/" || b == "&" || b == "|" || b == "!" || b == "="
                     || b == "<" || b == ">") begin
          pend_nxt = b; mode_nxt = M_SYM;
        end else if (single_tok(b) != TK_END) begin
          rr[n[0]] = mk_res(RK_TOKEN, single_tok(b), '0, '0, '0, ER_NONE); n = n + 2'd1;
        end else begin
          rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_UNKNOWN); n = n + 2'd1;
          err_nxt = 1'b1;
        end
      end
    end

    // append one identifier byte
    if (do_add) begin
      if (cnt_nxt >= CntW'(MaxIdentLen)) begin
        rr[n[0]] = mk_res(RK_ERROR, TK_END, '0, '0, '0, ER_LONG); n = n + 2'd1;
        err_nxt = 1'b1; mode_nxt = M_IDLE;
      end else begin
        for (int k = 0; k < 3; k++)
          if (cnt_nxt >= KwLen[k] || kw_char(k, cnt_nxt[2:0]) != b) kwc_nxt[k] = 1'b0;
        cnt_nxt = cnt_nxt + 1'b1;
        rr[n[0]] = mk_res(RK_IBYTE, TK_END, '0, b, '0, ER_NONE); n = n + 2'd1;
      end
    end

    // end of text: end token and back to reset state
    if (endm) begin
      rr[n[0]] = mk_res(RK_TOKEN, TK_END, '0, '0, '0, ER_NONE); n = n + 2'd1;
      mode_nxt = M_IDLE; acc_nxt = '0; cnt_nxt = '0; kwc_nxt = 3'b111;
      pend_nxt = '0; nib_nxt = '0; err_nxt = 1'b0;
    end

    if (n == 2'd1) rr[0].last = 1'b1;
    if (n == 2'd2) rr[1].last = 1'b1;
  end

  assign n_res = n;
  assign res0  = rr[0];
  assign res1  = rr[1];

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; acc_r <= '0; cnt_r <= '0; kwc_r <= 3'b111;
      pend_r <= '0; nib_r <= '0; err_r <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt; acc_r <= acc_nxt; cnt_r <= cnt_nxt; kwc_r <= kwc_nxt;
      pend_r <= pend_nxt; nib_r <= nib_nxt; err_r <= err_nxt;
    end
  end

endmodule

// File: hdl/script_byte_lexer_unit.sv
// Script byte lexer top level: lexer core plus a four-entry result queue.
//
// Usage: source bytes enter on in_ch (src_byte, end_mark) with valid/ready;
// an item is taken when both are high. Each item gives zero, one or two
// results on out_ch, in order, the last one of an item flagged last_of_run.
// end_mark flushes the pending token, sends the end token and returns the
// lexer to its reset state.
// Results are registered in the queue when their item is taken.
// Throughput: one byte per cycle while the queue holds at most two results;
// in_ch.ready drops when fewer than two queue slots are free, so an item
// that makes two results while the receiver drains one per cycle slows
// the input.
// Reset (rst_n low, synchronous) empties the queue and puts the lexer in
// its idle state between tokens.
// A stalled receiver holds the head result steady; input stops once the
// queue cannot take two more results.
module script_byte_lexer_unit
  import sbl_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  sbl_in_if.sink  in_ch,
  sbl_out_if.source out_ch
);

  logic       fire;
  logic [1:0] n_res;
  res_t       res0, res1;
  res_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign in_ch.ready = cnt_r <= 3'd2;
  assign fire = in_ch.valid && in_ch.ready;
  assign pop  = out_ch.valid && out_ch.ready;

  sbl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .b     (in_ch.src_byte),
    .endm  (in_ch.end_mark),
    .n_res (n_res),
    .res0  (res0),
    .res1  (res1)
  );

  // result queue storage
  always_ff @(posedge clk) begin
    if (fire && n_res != 2'd0) q_r[wp_r] <= res0;
    if (fire && n_res == 2'd2) q_r[wp_r + 2'd1] <= res1;
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (fire) wp_r <= wp_r + n_res;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + (fire ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
    end
  end

  assign out_ch.valid        = cnt_r != 3'd0;
  assign out_ch.result_kind  = q_r[rp_r].kind;
  assign out_ch.token_kind   = q_r[rp_r].tok;
  assign out_ch.int_value    = q_r[rp_r].ival;
  assign out_ch.char_value   = q_r[rp_r].ch;
  assign out_ch.ident_length = q_r[rp_r].len;
  assign out_ch.error_code   = q_r[rp_r].err;
  assign out_ch.last_of_run  = q_r[rp_r].last;

endmodule

// File: sim/sbl_test_ifs.sv
`timescale 1ns / 1ps
// Testbench-side note: channel interfaces come from the RTL; this file holds the expected-result type.
package sbl_test_pkg;
  import sbl_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  tok;
    logic [31:0] ival;
    logic [7:0]  ch;
    logic [5:0]  len;
    logic [2:0]  err;
    logic        last;
  } lex_result_t;
endpackage

// File: sim/sbl_lex_checker.sv
`timescale 1ns / 1ps
// Checker: predicts lexer results from accepted input items and compares them.
module sbl_lex_checker
  import sbl_pkg::*;
  import sbl_test_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sbl_in_if    in_ch,
  sbl_out_if   out_ch,
  output int   fail_count,
  output int   pending_count,
  output int   result_count
);

  // predictor state
  mode_t       mode;
  logic [31:0] acc;
  int          icount;
  logic [2:0]  kw_cand;
  logic [7:0]  sym;
  logic [3:0]  hi_nib;
  logic        err_held;

  lex_result_t expected_q[$];
  lex_result_t step_q[$];

  function automatic bit kw_match(int k, int idx, logic [7:0] b);
    string w;
    w = (k == 0) ? "declare" : (k == 1) ? "true" : "false";
    return idx < w.len() && w[idx] == b;
  endfunction

  function automatic int kw_length(int k);
    return (k == 0) ? 7 : (k == 1) ? 4 : 5;
  endfunction

  function automatic logic [4:0] one_char_tok(logic [7:0] b);
    case (b)
      "+": return 5'd1;  "-": return 5'd2;  "*": return 5'd3;  "/": return 5'd4;
      "^": return 5'd5;  "~": return 5'd6;  ";": return 5'd7;  "%": return 5'd8;
      "(": return 5'd9;  ")": return 5'd10; ",": return 5'd11; "&": return 5'd12;
      "|": return 5'd13; "<": return 5'd14; ">": return 5'd15; "=": return 5'd16;
      "!": return 5'd17;
      default: return TK_END;
    endcase
  endfunction

  function automatic logic [4:0] two_char_tok(logic [7:0] a, logic [7:0] b);
    if (a == "&" && b == "&") return TK_AND2;
    if (a == "|" && b == "|") return TK_OR2;
    if (b == "=") begin
      if (a == "!") return TK_NE;
      if (a == "=") return TK_EQ;
      if (a == "<") return TK_LE;
      if (a == ">") return TK_GE;
    end
    return TK_END;
  endfunction

  function automatic int nibble(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return 16;
  endfunction

  function automatic bit white(logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic push(logic [1:0] k, logic [4:0] t, logic [31:0] v, logic [7:0] c,
                      logic [5:0] l, logic [2:0] e);
    lex_result_t r;
    r = '{kind: k, tok: t, ival: v, ch: c, len: l, err: e, last: 1'b0};
    step_q.insert(step_q.size(), r);
  endtask

  task automatic flag_error(logic [2:0] code);
    push(RK_ERROR, TK_END, '0, '0, '0, code);
    err_held = 1'b1;
    mode = M_IDLE;
  endtask

  task automatic reset_state();
    mode = M_IDLE; acc = '0; icount = 0; kw_cand = 3'b111;
    sym = '0; hi_nib = '0; err_held = 1'b0;
  endtask

  task automatic add_ident_byte(logic [7:0] b);
    if (icount >= MaxIdentLen) begin
      flag_error(ER_LONG);
      return;
    end
    for (int k = 0; k < 3; k++)
      if (icount >= kw_length(k) || !kw_match(k, icount, b)) kw_cand[k] = 1'b0;
    icount++;
    push(RK_IBYTE, TK_END, '0, b, '0, ER_NONE);
  endtask

  // close out whatever token the current mode holds
  task automatic close_token();
    logic [4:0] t;
    case (mode)
      M_SYM: push(RK_TOKEN, one_char_tok(sym), '0, '0, '0, ER_NONE);
      M_IDENT: begin
        t = TK_IDENT;
        for (int k = 0; k < 3; k++)
          if (kw_cand[k] && icount == kw_length(k)) t = TK_KW0 + 5'(k);
        push(RK_TOKEN, t, '0, '0, icount[5:0], ER_NONE);
      end
      M_ZERO, M_DEC, M_OCT, M_HEX: push(RK_TOKEN, TK_INT, acc, '0, '0, ER_NONE);
      M_HEXSTART: flag_error(ER_HEX);
      M_STR: flag_error(ER_UNTERM);
      M_STRESC, M_STRHEX1, M_STRHEX2: flag_error(ER_ESCAPE);
      default: ;
    endcase
    mode = M_IDLE;
  endtask

  task automatic open_token(logic [7:0] b);
    logic [4:0] t;
    t = one_char_tok(b);
    if (white(b)) return;
    if (b == "\"") mode = M_STR;
    else if (b == "_" || letter(b)) begin
      mode = M_IDENT; icount = 0; kw_cand = 3'b111;
      add_ident_byte(b);
    end else if (digit(b)) begin
      acc = {24'd0, b - "0"};
      mode = (b == "0") ? M_ZERO : M_DEC;
    end else if (b == "/" ||
                 two_char_tok(b, (b == "&" || b == "|") ? b : 8'("=")) != TK_END) begin
      sym = b; mode = M_SYM;
    end else if (t != TK_END) push(RK_TOKEN, t, '0, '0, '0, ER_NONE);
    else flag_error(ER_UNKNOWN);
  endtask

  task automatic escape_byte(logic [7:0] b);
    logic [7:0] c;
    c = b;
    case (b)
      "a": c = 8'd7;  "b": c = 8'd8;  "f": c = 8'd12; "n": c = 8'd10;
      "r": c = 8'd13; "t": c = 8'd9;  "v": c = 8'd11;
      "x": begin mode = M_STRHEX1; return; end
      default: ;
    endcase
    if (c == 8'd0) begin
      flag_error(ER_ESCAPE);
      return;
    end
    mode = M_STR;
    push(RK_SBYTE, TK_END, '0, c, '0, ER_NONE);
  endtask

  task automatic lex_one(logic [7:0] b);
    int h;
    logic [4:0] t;
    h = nibble(b);
    case (mode)
      M_COMMENT: begin
        if (b == 8'd13 || b == 8'd10) mode = M_IDLE;
        return;
      end
      M_SYM: begin
        if (sym == "/" && b == "/") begin mode = M_COMMENT; return; end
        t = two_char_tok(sym, b);
        if (t != TK_END) begin
          push(RK_TOKEN, t, '0, '0, '0, ER_NONE); mode = M_IDLE; return;
        end
      end
      M_IDENT: if (b == "_" || letter(b) || digit(b)) begin add_ident_byte(b); return; end
      M_ZERO: begin
        if (b == "x") begin acc = '0; mode = M_HEXSTART; return; end
        if (b >= "0" && b <= "7") begin acc = {24'd0, b - "0"}; mode = M_OCT; return; end
      end
      M_OCT: if (b >= "0" && b <= "7") begin
        acc = (acc << 3) + {24'd0, b - "0"}; return;
      end
      M_DEC: if (digit(b)) begin acc = acc * 32'd10 + {24'd0, b - "0"}; return; end
      M_HEXSTART: begin
        if (h > 15) flag_error(ER_HEX);
        else begin acc = h; mode = M_HEX; end
        return;
      end
      M_HEX: if (h <= 15) begin acc = (acc << 4) + h; return; end
      M_STR: begin
        if (b == "\"") begin push(RK_TOKEN, TK_STRING, '0, '0, '0, ER_NONE); mode = M_IDLE; end
        else if (b == 8'd13 || b == 8'd10) flag_error(ER_UNTERM);
        else if (b == "\\") mode = M_STRESC;
        else push(RK_SBYTE, TK_END, '0, b, '0, ER_NONE);
        return;
      end
      M_STRESC: begin escape_byte(b); return; end
      M_STRHEX1: begin
        if (h > 15) flag_error(ER_ESCAPE);
        else begin hi_nib = h[3:0]; mode = M_STRHEX2; end
        return;
      end
      M_STRHEX2: begin
        if (h > 15 || {hi_nib, h[3:0]} == 8'd0) flag_error(ER_ESCAPE);
        else begin
          push(RK_SBYTE, TK_END, '0, {hi_nib, h[3:0]}, '0, ER_NONE); mode = M_STR;
        end
        return;
      end
      default: mode = M_IDLE;
    endcase
    close_token();
    if (!err_held) open_token(b);
  endtask

  // one accepted item -> its expected results
  task automatic predict_item(logic [7:0] b, logic end_in);
    step_q.delete();
    if (end_in) begin
      if (!err_held) close_token();
      push(RK_TOKEN, TK_END, '0, '0, '0, ER_NONE);
      reset_state();
    end else if (!err_held) lex_one(b);
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
  endtask

  always @(posedge clk) begin
    lex_result_t got, want;
    if (!rst_n) begin
      reset_state();
      expected_q.delete();
    end else begin
      // compare before predicting: a result is never popped in the same cycle as its item is taken
      if (out_ch.valid && out_ch.ready) begin
        got = '{kind: out_ch.result_kind, tok: out_ch.token_kind, ival: out_ch.int_value,
                ch: out_ch.char_value, len: out_ch.ident_length, err: out_ch.error_code,
                last: out_ch.last_of_run};
        result_count++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_item(in_ch.src_byte, in_ch.end_mark);
    end
    pending_count = expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending_count = 0;
    result_count = 0;
  end

endmodule

// File: sim/script_byte_lexer_unit_test.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, source text stimulus, receiver stalls and verdict.
module script_byte_lexer_unit_test;

  logic clk;
  logic rst_n;
  int   fail_count, pending_count, result_count;
  int   cycle_count;
  int   items_sent;
  bit   calm;        // no random idling on either side
  bit   hold_off;    // long receiver stall
  logic [7:0] text_q[$];
  bit         end_q[$];

  sbl_in_if  in_ch();
  sbl_out_if out_ch();

  script_byte_lexer_unit u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  sbl_lex_checker u_check (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("script_byte_lexer_unit verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && (calm || $urandom_range(99) >= 28);
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.insert(text_q.size(), s[i]); end_q.insert(end_q.size(), 1'b0);
    end
  endtask

  task automatic add_end();
    text_q.insert(text_q.size(), 8'($urandom_range(255))); end_q.insert(end_q.size(), 1'b1);
  endtask

  task automatic add_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b); end_q.insert(end_q.size(), 1'b0);
  endtask

  function automatic string pick_fragment();
    string frags[$];
    string s;
    int n;
    frags = '{"declare ", "true", "false ", "decl", "trues", "_x9 ", "0x1F", "0XAB",
              "077", "0189", "4294967296 ", "0xffffffff1", "\"ab\\n\\x41\"", "\"q\\\"\"",
              "&&", "||", "!=", "==", "<=", ">=", "& |", "<>", "!x", "//note\n",
              "/ 3", "+-*^~;%(),", "\"\\t\\v\\a\\b\\f\\r\\z\"", " \t\r\n", "0x", "\"x",
              "\"\\x4", "\"\\xg", "\"\\x00\"", "@", "\"\\", "a1_B2 ", "9999999999"};
    s = frags[$urandom_range(frags.size()-1)];
    // sometimes a long identifier
    if ($urandom_range(30) == 0) begin
      n = $urandom_range(60, 66);
      s = "";
      for (int i = 0; i < n; i++) s = {s, "z"};
      s = {s, " "};
    end
    return s;
  endfunction

  // sender
  initial begin
    logic [7:0] b;
    bit last_end;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.src_byte = 8'd0; in_ch.end_mark = 1'b0;
    calm = 1'b0; items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    add_text("declare x=0x7fFFffff;\"\\x41\\q\"");
    add_byte(8'd0); add_byte(8'd255); add_end();
    add_text("a<=b!=017//c\n"); add_end();
    // random part: mostly well-formed fragments, some noise
    while (text_q.size() < 1300) begin
      if ($urandom_range(9) == 0) add_byte(8'($urandom_range(255)));
      else add_text(pick_fragment());
      if ($urandom_range(12) == 0) add_end();
    end
    add_end();

    while (text_q.size() > 0) begin
      calm = items_sent > 400 && items_sent < 600;
      if (!calm && $urandom_range(99) < 28) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        continue;
      end
      b = text_q.pop_front(); last_end = end_q.pop_front();
      in_ch.valid <= 1'b1; in_ch.src_byte <= b; in_ch.end_mark <= last_end;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      items_sent++;
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Lexed %0d source items into %0d checked results, incl. a long receiver stall.",
             items_sent, result_count);
    if (fail_count == 0) $display("script_byte_lexer_unit verification clean");
    else $display("script_byte_lexer_unit verification failed");
    $finish;
  end

  // long hold-off partway through, counted in its own process
  initial begin
    int n;
    hold_off = 1'b0;
    wait (items_sent == 300);
    hold_off = 1'b1;
    n = 0;
    while (n < 60) begin
      @(posedge clk);
      n++;
    end
    hold_off = 1'b0;
  end

endmodule
